// ===== design/assert_macros.svh =====
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/rhhi_pkg.sv =====
`default_nettype none

package rhhi_pkg;

   localparam int unsigned HASH_W        = 32;
   localparam int unsigned HANDLE_W      = 32;
   localparam int unsigned DIST_W        = 8;
   localparam int unsigned CFG_W         = 11;
   localparam int unsigned HOME_W        = 10;
   localparam int unsigned MIN_SLOTS     = 8;
   localparam int unsigned RESET_SLOTS   = 8;
   localparam int unsigned DEF_MAX_SLOTS = 1024;
   localparam int unsigned DEF_MAX_PROBE = 255;

   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned DIV_STEPS  = HASH_W / DIGIT_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } rhhi_div_stat_type;

endpackage

`default_nettype wire

// ===== design/rhhi_mod_unit.sv =====
`default_nettype none

module rhhi_mod_unit #(
   parameter int unsigned MAX_SLOTS = rhhi_pkg::DEF_MAX_SLOTS,
   localparam int unsigned IDX_W = $clog2(MAX_SLOTS),
   localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rhhi_pkg::HASH_W-1:0]     dividend,
   input  logic [CNT_W-1:0]                divisor,
   output rhhi_pkg::rhhi_div_stat_type     stat,
   output logic [IDX_W-1:0]                remainder
);
   import rhhi_pkg::*;

   localparam int unsigned WW = IDX_W + 1;

   logic [HASH_W-1:0]    src_ff, src_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [WW-1:0]        trial;
   logic [IDX_W-1:0]     acc;

   // one digit of the hash per cycle, restoring remainder bit by bit
   always_comb begin
      acc = rem_ff;
      trial = '0;
      for (int i = 0; i < int'(DIGIT_W); i++) begin
         trial = {acc, src_ff[HASH_W-1-i]};
         if (trial >= WW'(div_ff)) begin
            trial = trial - WW'(div_ff);
         end
         acc = trial[IDX_W-1:0];
      end
   end

   always_comb begin
      src_in  = src_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         src_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = acc;
         src_in = src_ff << DIGIT_W;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/rhhi_slot_mem.sv =====
`default_nettype none

module rhhi_slot_mem #(
   parameter int unsigned MAX_SLOTS = rhhi_pkg::DEF_MAX_SLOTS,
   localparam int unsigned IDX_W   = $clog2(MAX_SLOTS),
   localparam int unsigned ENTRY_W = rhhi_pkg::DIST_W + rhhi_pkg::HANDLE_W
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);
   import rhhi_pkg::*;

   logic [ENTRY_W-1:0] slot_mem_ff [MAX_SLOTS];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/robin_hood_hash_insert_unit.sv =====
// channel  direction  ports                                          handshake
// req      in         req_key_hash req_value_handle req_start_build  req_valid/req_ready
// rsp      out        rsp_status rsp_home_slot rsp_probe_length      rsp_valid/rsp_ready
// csr      in         csr_wr_data                                    csr_wr_en, no wait
//
// After a word is accepted, its hash is first reduced modulo the slot count, 4 hash bits
// at a time; then the slots are probed, one slot read-modify-write a cycle.
// A word with req_start_build set first sweeps all MAX_SLOTS entries to zero, one a cycle.
// After reset the same sweep runs with req_ready low.
// A result waits in the output register; the next word is accepted meanwhile, and its
// result is held back until that register is free.
`default_nettype none
`include "assert_macros.svh"

module robin_hood_hash_insert_unit #(
   parameter int unsigned MAX_SLOTS = rhhi_pkg::DEF_MAX_SLOTS,
   parameter int unsigned MAX_PROBE = rhhi_pkg::DEF_MAX_PROBE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rhhi_pkg::HASH_W-1:0]       req_key_hash,
   input  logic [rhhi_pkg::HANDLE_W-1:0]     req_value_handle,
   input  logic                              req_start_build,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_status,
   output logic [rhhi_pkg::HOME_W-1:0]       rsp_home_slot,
   output logic [rhhi_pkg::DIST_W-1:0]       rsp_probe_length,
   input  logic                              csr_wr_en,
   input  logic [rhhi_pkg::CFG_W-1:0]        csr_wr_data
);
   import rhhi_pkg::*;

   localparam int unsigned IDX_W   = $clog2(MAX_SLOTS);
   localparam int unsigned CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int unsigned ENTRY_W = DIST_W + HANDLE_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CLEAR    = 3'd1;
   localparam logic [2:0] ST_DIV_GO   = 3'd2;
   localparam logic [2:0] ST_DIV_WAIT = 3'd3;
   localparam logic [2:0] ST_PRIME    = 3'd4;
   localparam logic [2:0] ST_SCAN     = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic                item_ff, item_in;
   logic [CFG_W-1:0]    slot_count_ff, slot_count_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic                carry_ff, carry_in;
   logic [HANDLE_W-1:0] carry_handle_ff, carry_handle_in;
   logic                res_status_ff, res_status_in;
   logic [HOME_W-1:0]   res_home_ff, res_home_in;
   logic [DIST_W-1:0]   res_probe_ff, res_probe_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [HOME_W-1:0]   rsp_home_ff, rsp_home_in;
   logic [DIST_W-1:0]   rsp_probe_ff, rsp_probe_in;

   logic [CNT_W-1:0]    n_eff;
   logic [CNT_W-1:0]    idx_wide;
   logic [IDX_W-1:0]    idx_next;
   logic [DIST_W-1:0]   dist_inc;
   logic [DIST_W-1:0]   rd_dist;
   logic [HANDLE_W-1:0] rd_handle;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   logic [ENTRY_W-1:0]  mem_wd;
   logic [IDX_W-1:0]    mem_ra;
   logic [ENTRY_W-1:0]  mem_rd;

   logic                div_start;
   rhhi_div_stat_type   div_stat;
   logic [IDX_W-1:0]    div_rem;

   rhhi_mod_unit #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hash_ff),
      .divisor   (n_ff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   rhhi_slot_mem #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   always_comb begin
      priority if (slot_count_ff < CFG_W'(MIN_SLOTS)) begin
         n_eff = CNT_W'(MIN_SLOTS);
      end else if (32'(slot_count_ff) > MAX_SLOTS) begin
         n_eff = CNT_W'(MAX_SLOTS);
      end else begin
         n_eff = CNT_W'(slot_count_ff);
      end
   end

   assign idx_wide  = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_next  = (idx_wide == n_ff) ? '0 : IDX_W'(idx_wide);
   assign dist_inc  = dist_ff + DIST_W'(1);
   assign rd_dist   = mem_rd[ENTRY_W-1 -: DIST_W];
   assign rd_handle = mem_rd[HANDLE_W-1:0];

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      slot_count_in   = slot_count_ff;
      clr_idx_in      = clr_idx_ff;
      hash_in         = hash_ff;
      handle_in       = handle_ff;
      n_in            = n_ff;
      idx_in          = idx_ff;
      dist_in         = dist_ff;
      carry_in        = carry_ff;
      carry_handle_in = carry_handle_ff;
      res_status_in   = res_status_ff;
      res_home_in     = res_home_ff;
      res_probe_in    = res_probe_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_home_in     = rsp_home_ff;
      rsp_probe_in    = rsp_probe_ff;
      mem_we          = 1'b0;
      mem_wa          = idx_ff;
      mem_wd          = '0;
      mem_ra          = idx_ff;
      div_start       = 1'b0;

      if (csr_wr_en) begin
         slot_count_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hash_in    = req_key_hash;
               handle_in  = req_value_handle;
               n_in       = n_eff;
               item_in    = 1'b1;
               clr_idx_in = '0;
               state_in   = req_start_build ? ST_CLEAR : ST_DIV_GO;
            end
         end
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(MAX_SLOTS - 1)) begin
               state_in = item_ff ? ST_DIV_GO : ST_IDLE;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            mem_ra   = div_rem;
            idx_in   = div_rem;
            dist_in  = DIST_W'(1);
            carry_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            mem_ra = idx_next;
            idx_in = idx_next;
            if (!carry_ff) begin
               if (dist_ff > rd_dist) begin
                  // claim the slot, evicting its resident if it is occupied
                  mem_we        = 1'b1;
                  mem_wd        = {dist_ff, handle_ff};
                  res_status_in = STATUS_OK;
                  res_home_in   = HOME_W'(idx_ff);
                  res_probe_in  = dist_ff;
                  if (rd_dist == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     carry_in        = 1'b1;
                     dist_in         = rd_dist;
                     carry_handle_in = rd_handle;
                  end
               end else if (dist_ff >= DIST_W'(MAX_PROBE)) begin
                  res_status_in = STATUS_OVERFLOW;
                  res_home_in   = '0;
                  res_probe_in  = '0;
                  state_in      = ST_DONE;
               end else begin
                  dist_in = dist_inc;
               end
            end else begin
               if (dist_ff >= DIST_W'(MAX_PROBE)) begin
                  // drop the carried entry, keep what is written
                  res_status_in = STATUS_OVERFLOW;
                  res_home_in   = '0;
                  res_probe_in  = '0;
                  state_in      = ST_DONE;
               end else if (rd_dist < dist_inc) begin
                  mem_we = 1'b1;
                  mem_wd = {dist_inc, carry_handle_ff};
                  if (rd_dist == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     dist_in         = rd_dist;
                     carry_handle_in = rd_handle;
                  end
               end else begin
                  dist_in = dist_inc;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_home_in   = res_home_ff;
               rsp_probe_in  = res_probe_ff;
               item_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         item_ff       <= 1'b0;
         clr_idx_ff    <= '0;
         carry_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_count_ff <= CFG_W'(RESET_SLOTS);
      end else begin
         state_ff      <= state_in;
         item_ff       <= item_in;
         clr_idx_ff    <= clr_idx_in;
         carry_ff      <= carry_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_count_ff <= slot_count_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff         <= hash_in;
      handle_ff       <= handle_in;
      n_ff            <= n_in;
      idx_ff          <= idx_in;
      dist_ff         <= dist_in;
      carry_handle_ff <= carry_handle_in;
      res_status_ff   <= res_status_in;
      res_home_ff     <= res_home_in;
      res_probe_ff    <= res_probe_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_home_ff     <= rsp_home_in;
      rsp_probe_ff    <= rsp_probe_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_home_slot    = rsp_home_ff;
   assign rsp_probe_length = rsp_probe_ff;

   `ASSERT_SAME(a_scan_no_rw_clash, clock, reset,
                (state_ff == ST_SCAN) && mem_we, mem_wa != mem_ra)
   `ASSERT_SAME(a_scan_idx_in_range, clock, reset,
                state_ff == ST_SCAN, CNT_W'(idx_ff) < n_ff)
   `ASSERT_NEXT(a_done_holds, clock, reset,
                (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE)
   `ASSERT_SAME(a_prime_div_ready, clock, reset,
                state_ff == ST_PRIME, div_stat.done && !div_stat.busy)
   `ASSERT_SAME(a_overflow_zero, clock, reset,
                rsp_valid_ff && (rsp_status_ff == STATUS_OVERFLOW),
                (rsp_home_ff == '0) && (rsp_probe_ff == '0))

endmodule

`default_nettype wire
